// ===== design/tpc_pkg.sv =====
// Shared types and constants for the trajectory proximity cost block.
// No dependencies; used by tpc_isqrt, tpc_div and trajectory_proximity_cost.
package tpc_pkg;

   localparam int COORD_W    = 32;  // Q16.16 coordinate
   localparam int DIST_W     = 32;  // Q16.16 distance
   localparam int COST_W     = 32;
   localparam int REG_W      = 31;  // safety distance / lookahead width
   localparam int SQ_W       = 64;  // squared distance without carry
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_COLLISION_COST  = 2'd0,
      REG_SAFETY_DISTANCE = 2'd1,
      REG_LOOKAHEAD       = 2'd2
   } csr_index_type;

   // status of an iterative arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;   // one-cycle pulse when the result is valid
   } unit_status_type;

endpackage

// ===== design/trajectory_proximity_cost.sv =====
// Trajectory proximity cost: top level, point store, sequencer and shared multiplier.
// Depends on tpc_pkg, tpc_isqrt and tpc_div.
// Sequence: a query fetches entry zero, then for each stored point forms the differences and
//   squares them on the shared 32x32 multiplier, folds in the last sum, takes the square root,
//   checks the cost band, multiplies and divides inside the band, and registers the output; a
//   saturated distance skips the root, and an empty store goes straight to the output.
// Throughput: loads back to back; a query holds req_tready low until its result is registered.
// Reset: synchronous, active high; clears the point count and restores register defaults.
module trajectory_proximity_cost #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [63:0]                       req_tdata,   // x[31:0], y[63:32]
   input  logic [1:0]                        req_tuser,   // func[0], first[1]
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [63:0]                       rsp_tdata,   // cost[31:0], min_dist[63:32]
   output logic                              rsp_tuser,   // empty_res[0]
   // configuration write port
   input  logic                              csr_we,
   input  logic [tpc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int CW_L = CW;  // count and index share a width
   localparam logic [CW_L-1:0] MAX_COUNT = CW_L'(MAX_POINTS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_LAST,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_COST,
      ST_MULC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   // configuration registers
   logic [tpc_pkg::COST_W-1:0]  coll_cost_ff;
   logic [tpc_pkg::REG_W-1:0]   safety_ff;
   logic [tpc_pkg::REG_W-1:0]   lookahead_ff;

   // point store: x in the low word, y in the high word
   logic [2*tpc_pkg::COORD_W-1:0] point_mem [MAX_POINTS];
   logic [2*tpc_pkg::COORD_W-1:0] rd_data_ff;

   state_type                     state_ff;
   logic [CW_L-1:0]               count_ff;
   logic [CW_L-1:0]               idx_ff;
   logic                          pend_ff;   // a squared pair waits to be summed
   logic [tpc_pkg::COORD_W-1:0]   qx_ff;
   logic [tpc_pkg::COORD_W-1:0]   qy_ff;
   logic [tpc_pkg::COORD_W-1:0]   ax_ff;
   logic [tpc_pkg::COORD_W-1:0]   ay_ff;
   logic [tpc_pkg::SQ_W-1:0]      prod_ff;
   logic [tpc_pkg::SQ_W-1:0]      sx_ff;
   logic [tpc_pkg::SQ_W:0]        best_ff;
   logic [tpc_pkg::DIST_W-1:0]    dist_ff;
   logic [tpc_pkg::DIST_W-1:0]    band_ff;
   logic [tpc_pkg::COST_W-1:0]    cost_ff;
   logic                          empty_ff;

   logic                          rsp_valid_ff;
   logic [63:0]                   rsp_data_ff;
   logic                          rsp_user_ff;

   // request decode
   logic                          req_beat;
   logic                          req_func;
   logic                          req_first;
   logic [tpc_pkg::COORD_W-1:0]   req_x;
   logic [tpc_pkg::COORD_W-1:0]   req_y;
   logic                          load_wr;
   logic [AW-1:0]                 wr_addr;

   // point arithmetic
   logic [tpc_pkg::COORD_W:0]     dx;
   logic [tpc_pkg::COORD_W:0]     dy;
   logic [tpc_pkg::COORD_W:0]     dx_mag;
   logic [tpc_pkg::COORD_W:0]     dy_mag;
   logic [tpc_pkg::SQ_W:0]        sum_sq;
   logic                          sum_better;
   logic [tpc_pkg::COORD_W-1:0]   mul_a;
   logic [tpc_pkg::COORD_W-1:0]   mul_b;
   logic [tpc_pkg::SQ_W-1:0]      mul_p;
   logic [tpc_pkg::DIST_W-1:0]    band_end;
   logic                          out_free;

   // iterative units
   logic                          sqrt_start;
   logic [tpc_pkg::DIST_W-1:0]    sqrt_root;
   tpc_pkg::unit_status_type      sqrt_status;
   logic                          div_start;
   logic [tpc_pkg::COST_W-1:0]    div_quot;
   tpc_pkg::unit_status_type      div_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign req_func   = req_tuser[0];
   assign req_first  = req_tuser[1];
   assign req_x      = req_tdata[tpc_pkg::COORD_W-1:0];
   assign req_y      = req_tdata[2*tpc_pkg::COORD_W-1:tpc_pkg::COORD_W];

   // a load stores unless the store is full; first restarts at entry zero
   assign load_wr = req_beat && !req_func && (req_first || (count_ff < MAX_COUNT));
   assign wr_addr = req_first ? '0 : count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (load_wr) begin
         point_mem[wr_addr] <= req_tdata;
      end
      rd_data_ff <= point_mem[idx_ff[AW-1:0]];
   end

   // absolute coordinate differences, 33-bit signed then magnitude
   assign dx     = {qx_ff[tpc_pkg::COORD_W-1], qx_ff}
                 - {rd_data_ff[tpc_pkg::COORD_W-1], rd_data_ff[tpc_pkg::COORD_W-1:0]};
   assign dy     = {qy_ff[tpc_pkg::COORD_W-1], qy_ff}
                 - {rd_data_ff[2*tpc_pkg::COORD_W-1],
                    rd_data_ff[2*tpc_pkg::COORD_W-1:tpc_pkg::COORD_W]};
   assign dx_mag = dx[tpc_pkg::COORD_W] ? (~dx + 1'b1) : dx;
   assign dy_mag = dy[tpc_pkg::COORD_W] ? (~dy + 1'b1) : dy;

   // 65-bit sum keeps the carry so huge distances compare right
   assign sum_sq     = {1'b0, sx_ff} + {1'b0, prod_ff};
   assign sum_better = (sum_sq < best_ff);

   // shared multiplier: squares per point, then the collision cost times band depth
   always_comb begin
      case (state_ff)
         ST_SQY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         ST_MULC: begin
            mul_a = coll_cost_ff;
            mul_b = band_ff;
         end
         default: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign band_end = {1'b0, safety_ff} + {1'b0, lookahead_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign sqrt_start = (state_ff == ST_SQRT_GO) && !best_ff[tpc_pkg::SQ_W];
   assign div_start  = (state_ff == ST_DIV_GO);

   tpc_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (best_ff[tpc_pkg::SQ_W-1:0]),
      .root     (sqrt_root),
      .status   (sqrt_status)
   );

   tpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (lookahead_ff),
      .quotient (div_quot),
      .status   (div_status)
   );

   // configuration registers: restore defaults on reset, take the write, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         coll_cost_ff <= 32'd1000000;
         safety_ff    <= 31'd26214;
         lookahead_ff <= 31'd131072;
      end else if (csr_we) begin
         unique case (csr_addr)
            tpc_pkg::REG_COLLISION_COST:  coll_cost_ff <= csr_wdata;
            tpc_pkg::REG_SAFETY_DISTANCE: safety_ff    <= csr_wdata[tpc_pkg::REG_W-1:0];
            tpc_pkg::REG_LOOKAHEAD:       lookahead_ff <= csr_wdata[tpc_pkg::REG_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a taken result unless the output state refills the register
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  qx_ff <= req_x;
                  qy_ff <= req_y;
                  if (!req_func) begin
                     // load: count follows the write
                     if (req_first) begin
                        count_ff <= CW_L'(1);
                     end else if (count_ff < MAX_COUNT) begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end else if (count_ff == '0) begin
                     cost_ff  <= '0;
                     dist_ff  <= '1;
                     empty_ff <= 1'b1;
                     state_ff <= ST_OUT;
                  end else begin
                     idx_ff   <= '0;
                     pend_ff  <= 1'b0;
                     best_ff  <= '1;
                     empty_ff <= 1'b0;
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               // read of entry zero lands in rd_data_ff
               state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               // fold the previous point in while this one is differenced
               if (pend_ff && sum_better) begin
                  best_ff <= sum_sq;
               end
               ax_ff    <= dx_mag[tpc_pkg::COORD_W-1:0];
               ay_ff    <= dy_mag[tpc_pkg::COORD_W-1:0];
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= ST_SQX;
            end
            ST_SQX: begin
               prod_ff  <= mul_p;
               state_ff <= ST_SQY;
            end
            ST_SQY: begin
               sx_ff    <= prod_ff;
               prod_ff  <= mul_p;
               pend_ff  <= 1'b1;
               state_ff <= (idx_ff == count_ff) ? ST_LAST : ST_DIFF;
            end
            ST_LAST: begin
               if (sum_better) begin
                  best_ff <= sum_sq;
               end
               state_ff <= ST_SQRT_GO;
            end
            ST_SQRT_GO: begin
               if (best_ff[tpc_pkg::SQ_W]) begin
                  dist_ff  <= '1;
                  state_ff <= ST_COST;
               end else begin
                  state_ff <= ST_SQRT_WAIT;
               end
            end
            ST_SQRT_WAIT: begin
               if (sqrt_status.done) begin
                  dist_ff  <= sqrt_root;
                  state_ff <= ST_COST;
               end
            end
            ST_COST: begin
               if (dist_ff < {1'b0, safety_ff}) begin
                  cost_ff  <= coll_cost_ff;
                  state_ff <= ST_OUT;
               end else if ((lookahead_ff != '0) && (dist_ff < band_end)) begin
                  band_ff  <= band_end - dist_ff;
                  state_ff <= ST_MULC;
               end else begin
                  cost_ff  <= '0;
                  state_ff <= ST_OUT;
               end
            end
            ST_MULC: begin
               prod_ff  <= mul_p;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_status.done) begin
                  cost_ff  <= div_quot;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // hold until the result register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {dist_ff, cost_ff};
                  rsp_user_ff  <= empty_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== design/tpc_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
// Depends on tpc_pkg.
module tpc_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tpc_pkg::SQ_W-1:0]     radicand,
   output logic [tpc_pkg::DIST_W-1:0]   root,
   output tpc_pkg::unit_status_type     status
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [4:0]                   step_ff;
   logic [tpc_pkg::SQ_W-1:0]     rad_ff;
   logic [tpc_pkg::DIST_W+1:0]   rem_ff;
   logic [tpc_pkg::DIST_W-1:0]   root_ff;

   logic [tpc_pkg::DIST_W+1:0]   rem_sh;
   logic [tpc_pkg::DIST_W+1:0]   trial;
   logic                         ge;

   assign rem_sh = {rem_ff[tpc_pkg::DIST_W-1:0], rad_ff[tpc_pkg::SQ_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign ge     = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: two radicand bits in, one root bit out per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[tpc_pkg::SQ_W-3:0], 2'b00};
         rem_ff  <= ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[tpc_pkg::DIST_W-2:0], ge};
      end
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== design/tpc_div.sv =====
// Iterative restoring divider: 64-bit dividend by 31-bit divisor, 32-bit quotient.
// Needs dividend[63:32] below the divisor. Depends on tpc_pkg.
module tpc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tpc_pkg::SQ_W-1:0]     dividend,
   input  logic [tpc_pkg::REG_W-1:0]    divisor,
   output logic [tpc_pkg::COST_W-1:0]   quotient,
   output tpc_pkg::unit_status_type     status
);

   logic                         busy_ff;
   logic                         done_ff;
   logic [4:0]                   step_ff;
   logic [tpc_pkg::REG_W-1:0]    den_ff;
   logic [tpc_pkg::REG_W-1:0]    rem_ff;
   logic [tpc_pkg::COST_W-1:0]   quo_ff;

   logic [tpc_pkg::REG_W:0]      rem_sh;
   logic                         ge;
   logic [tpc_pkg::REG_W:0]      rem_sub;

   assign rem_sh  = {rem_ff, quo_ff[tpc_pkg::COST_W-1]};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift one dividend bit in, one quotient bit out per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         rem_ff <= dividend[tpc_pkg::SQ_W-2 -: tpc_pkg::REG_W];
         quo_ff <= dividend[tpc_pkg::COST_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sub[tpc_pkg::REG_W-1:0] : rem_sh[tpc_pkg::REG_W-1:0];
         quo_ff <= {quo_ff[tpc_pkg::COST_W-2:0], ge};
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
